/* design/mexp_pkg.sv */
// Shared types and constants for the modular exponentiation block.
package mexp_pkg;

	// Width of every port field.
	localparam int FIELD_W = 32;

	// Per-cycle control for one bit-serial modular multiply accumulator.
	typedef struct packed {
		logic clr;     // zero the accumulator
		logic step;    // take one multiplier bit this cycle
		logic bit_in;  // multiplier bit, MSB first
	} mexp_ctl_t;

endpackage

/* design/mexp_mulacc.sv */
// Bit-serial modular multiply accumulator: acc = 2*acc + bit*a, reduced mod m.
module mexp_mulacc #(
	parameter int WIDTH = 32
) (
	input  logic               clk,
	input  mexp_pkg::mexp_ctl_t ctl,
	input  logic [WIDTH-1:0]   a,
	input  logic [WIDTH:0]     mod_ext,  // modulus, 2^WIDTH when the register is zero
	output logic [WIDTH-1:0]   acc
);
	import mexp_pkg::*;

	logic [WIDTH-1:0] acc_q;
	logic [WIDTH:0]   dbl;
	logic [WIDTH-1:0] dbl_red;
	logic [WIDTH:0]   sum;
	logic [WIDTH-1:0] sum_red;

	always_comb begin
		// doubling: acc < m, so 2*acc < 2m and one subtract is enough
		dbl = {acc_q, 1'b0};
		if (dbl >= mod_ext) begin
			dbl = dbl - mod_ext;
		end
		dbl_red = dbl[WIDTH-1:0];
		// add the multiplicand when the bit is set; again below 2m
		sum = {1'b0, dbl_red} + (ctl.bit_in ? {1'b0, a} : '0);
		if (sum >= mod_ext) begin
			sum = sum - mod_ext;
		end
		sum_red = sum[WIDTH-1:0];
	end

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.step) begin
			acc_q <= sum_red;
		end
	end

	assign acc = acc_q;

endmodule

/* design/modular_exponentiation_top.sv */
// Top level: base^exponent mod modulus by right-to-left square and multiply.
//
//  channel   direction  handshake              payload
//  in        sink       in_valid / in_stall    base_value[31:0], exponent[31:0]
//  out       source     out_valid / out_stall  power_result[31:0]
//  cfg       sink       cfg_wr_en              cfg_wr_data[31:0] -> modulus
//
// One item at a time. A zero exponent goes straight to the result. Otherwise the
// base is first reduced mod m, then each exponent bit up to the highest set one
// takes one multiply pass and one update step. In a multiply pass the two
// bit-serial multiply accumulators run side by side, one multiplier bit per
// cycle.
// arst_n clears control and sets the modulus to 1. A result held under
// out_stall keeps the block busy; in_stall is high until it is taken.
module modular_exponentiation_top #(
	parameter int WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_wr_en,
	input  logic [mexp_pkg::FIELD_W-1:0]  cfg_wr_data,
	// input transfer
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mexp_pkg::FIELD_W-1:0]  base_value,
	input  logic [mexp_pkg::FIELD_W-1:0]  exponent,
	// output transfer
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mexp_pkg::FIELD_W-1:0]  power_result
);
	import mexp_pkg::*;

	localparam int CNT_W = $clog2(WIDTH);

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;  // waiting for an input transfer
	localparam logic [2:0] S_RED  = 3'd1;  // base mod m, one base bit per cycle
	localparam logic [2:0] S_UPD  = 3'd2;  // fold products back, pick next bit
	localparam logic [2:0] S_MUL  = 3'd3;  // r*p and p*p side by side
	localparam logic [2:0] S_DONE = 3'd4;  // result waiting for output transfer

	logic [2:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             from_mul_q;  // UPD entered after a multiply pass
	logic [FIELD_W-1:0] mod_q;     // config register

	logic [WIDTH-1:0] p_q;         // current power of the base
	logic [WIDTH-1:0] r_q;         // running result
	logic [WIDTH-1:0] psh_q;       // multiplier bits, shifted out MSB first
	logic [WIDTH-1:0] e_q;         // remaining exponent
	logic [WIDTH-1:0] res_q;

	logic [WIDTH-1:0] mod_w;
	logic [WIDTH:0]   mod_ext;
	logic [WIDTH-1:0] base_w;
	logic [WIDTH-1:0] exp_w;
	logic             in_xfer;
	logic             last_bit;
	logic [WIDTH-1:0] r_nx;
	logic [WIDTH-1:0] e_nx;

	mexp_ctl_t        r_ctl;
	mexp_ctl_t        p_ctl;
	logic [WIDTH-1:0] p_a;
	logic [WIDTH-1:0] r_acc;
	logic [WIDTH-1:0] p_acc;

	// fields and modulus masked to the datapath width
	assign mod_w   = WIDTH'(mod_q);
	assign base_w  = WIDTH'(base_value);
	assign exp_w   = WIDTH'(exponent);
	// a zero modulus means plain wraparound mod 2^WIDTH
	assign mod_ext = (mod_w == '0) ? {1'b1, {WIDTH{1'b0}}} : {1'b0, mod_w};

	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_valid = (state_q == S_DONE);
	assign power_result = FIELD_W'(res_q);

	assign last_bit = (cnt_q == CNT_W'(WIDTH - 1));

	// after a multiply pass the low exponent bit decides whether r takes r*p
	assign r_nx = (from_mul_q && e_q[0]) ? r_acc : r_q;
	assign e_nx = from_mul_q ? (e_q >> 1) : e_q;

	// accumulator control; both clear on a new item and before each pass
	always_comb begin
		p_ctl.clr    = in_xfer || (state_q == S_UPD);
		p_ctl.step   = (state_q == S_RED) || (state_q == S_MUL);
		p_ctl.bit_in = psh_q[WIDTH-1] && p_ctl.step;
		r_ctl.clr    = p_ctl.clr;
		r_ctl.step   = (state_q == S_MUL);
		r_ctl.bit_in = psh_q[WIDTH-1] && r_ctl.step;
		// reduction is 1 * base mod m, so the multiplicand is one there
		p_a = (state_q == S_RED) ? WIDTH'(1) : p_q;
	end

	mexp_mulacc #(.WIDTH(WIDTH)) u_r_mac (
		.clk     (clk),
		.ctl     (r_ctl),
		.a       (r_q),
		.mod_ext (mod_ext),
		.acc     (r_acc)
	);

	mexp_mulacc #(.WIDTH(WIDTH)) u_p_mac (
		.clk     (clk),
		.ctl     (p_ctl),
		.a       (p_a),
		.mod_ext (mod_ext),
		.acc     (p_acc)
	);

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= FIELD_W'(1);
		end else if (cfg_wr_en) begin
			mod_q <= cfg_wr_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			from_mul_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						cnt_q      <= '0;
						from_mul_q <= 1'b0;
						state_q    <= (exp_w == '0) ? S_DONE : S_RED;
					end
				end
				S_RED: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (last_bit) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					cnt_q   <= '0;
					state_q <= (e_nx == '0) ? S_DONE : S_MUL;
				end
				S_MUL: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (last_bit) begin
						from_mul_q <= 1'b1;
						state_q    <= S_UPD;
					end
				end
				S_DONE: begin
					if (!out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					psh_q <= base_w;
					e_q   <= exp_w;
					res_q <= WIDTH'(1);  // zero exponent gives 1 even for m = 1
					r_q   <= (mod_ext == {{WIDTH{1'b0}}, 1'b1}) ? '0 : WIDTH'(1);
				end
			end
			S_RED, S_MUL: begin
				psh_q <= {psh_q[WIDTH-2:0], 1'b0};
			end
			S_UPD: begin
				p_q   <= p_acc;
				psh_q <= p_acc;
				r_q   <= r_nx;
				e_q   <= e_nx;
				res_q <= r_nx;
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

endmodule
